FILE: hw/rtl/cfa_pkg.sv
// shared types and constants for the carbohydrate flow rate block
package cfa_pkg;

    localparam int TIME_W = 24;
    localparam int AMT_W  = 20;
    localparam int RATE_W = 24;
    localparam int TSUM_W = AMT_W + 1;
    localparam int NUM_W  = 48;
    localparam int QUO_W  = RATE_W;
    localparam int WIDE_W = 50;
    localparam int CFG_W  = 24;

    localparam logic [1:0] REG_CARB = 2'd0;
    localparam logic [1:0] REG_RISE = 2'd1;
    localparam logic [1:0] REG_FALL = 2'd2;
    localparam logic [1:0] REG_PEAK = 2'd3;

    typedef enum logic [2:0] {
        MS_PROD,
        MS_SHAPE,
        MS_DIV,
        MS_ROOT,
        MS_HMUL,
        MS_READY
    } t_meal_state;

    // meal constants shared by every request
    typedef struct packed {
        logic [AMT_W-1:0]        tr;
        logic [AMT_W-1:0]        tf;
        logic [RATE_W-1:0]       v;
        logic [TSUM_W-1:0]       tsum;
        logic                    tri_mode;
        logic [WIDE_W-1:0]       n;
        logic [WIDE_W-1:0]       top;
        logic [AMT_W+RATE_W-1:0] htr;
        logic [TSUM_W+RATE_W-1:0] hsum;
    } t_meal;

    // division in flight: remainder, divisor, quotient so far
    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [TSUM_W-1:0] div;
        logic [QUO_W-1:0]  quo;
        logic              tri_mode;
    } t_cell;

endpackage

FILE: hw/rtl/cfa_meal.sv
// meal set-up sequencer: shape, plateau margin and triangle apex height
module cfa_meal #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [cfa_pkg::AMT_W-1:0]  i_carb,
    input  logic [cfa_pkg::AMT_W-1:0]  i_rise,
    input  logic [cfa_pkg::AMT_W-1:0]  i_fall,
    input  logic [cfa_pkg::RATE_W-1:0] i_peak,
    output logic                       o_busy,
    output cfa_pkg::t_meal             o_meal
);

    localparam int CVW   = cfa_pkg::AMT_W + cfa_pkg::RATE_W;
    localparam int DW    = CVW + FRAC_BITS + 1;
    localparam int CNT_W = $clog2(DW + 1);
    localparam int HW    = cfa_pkg::QUO_W;
    localparam int BIT_W = $clog2(HW);
    localparam int SQ_W  = 2 * HW;

    cfa_pkg::t_meal_state r_state, n_state;

    logic [cfa_pkg::AMT_W-1:0]  w_tr, w_tf;
    logic [cfa_pkg::RATE_W-1:0] w_v;
    logic [cfa_pkg::TSUM_W-1:0] w_tsum;

    logic [cfa_pkg::AMT_W-1:0]    r_tr, r_tf;
    logic [cfa_pkg::RATE_W-1:0]   r_v;
    logic [cfa_pkg::TSUM_W-1:0]   r_tsum;
    logic [cfa_pkg::TSUM_W+cfa_pkg::RATE_W-1:0] r_ramps;
    logic [CVW-1:0]               r_vtf, r_cv;
    logic                         r_tri;
    logic [cfa_pkg::WIDE_W-1:0]   r_n, r_top;
    logic [cfa_pkg::TSUM_W:0]     r_rem;
    logic [DW-1:0]                r_dq;
    logic [CNT_W-1:0]             r_cnt;
    logic [HW-1:0]                r_h;
    logic [BIT_W-1:0]             r_bit;
    logic [cfa_pkg::AMT_W+HW-1:0]  r_htr;
    logic [cfa_pkg::TSUM_W+HW-1:0] r_hsum;

    logic [cfa_pkg::WIDE_W-1:0] w_p, w_ramps;
    logic [cfa_pkg::TSUM_W:0]   w_shift;
    logic                       w_take;
    logic [HW-1:0]              w_cand;
    logic [SQ_W-1:0]            w_sq;

    assign w_tr   = (i_rise == '0) ? cfa_pkg::AMT_W'(1) : i_rise;
    assign w_tf   = (i_fall == '0) ? cfa_pkg::AMT_W'(1) : i_fall;
    assign w_v    = (i_peak == '0) ? cfa_pkg::RATE_W'(1) : i_peak;
    assign w_tsum = {1'b0, w_tr} + {1'b0, w_tf};

    assign w_p     = cfa_pkg::WIDE_W'({i_carb, {(FRAC_BITS + 1){1'b0}}});
    assign w_ramps = cfa_pkg::WIDE_W'(r_ramps);

    // restoring divide of carb*v*2^(F+1) by the ramp time sum
    assign w_shift = {r_rem[cfa_pkg::TSUM_W-1:0], r_dq[DW-1]};
    assign w_take  = w_shift >= {1'b0, r_tsum};

    assign w_cand = r_h | (HW'(1) << r_bit);
    assign w_sq   = w_cand * w_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfa_pkg::MS_PROD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfa_pkg::MS_PROD:  n_state = cfa_pkg::MS_SHAPE;
            cfa_pkg::MS_SHAPE: n_state = cfa_pkg::MS_DIV;
            cfa_pkg::MS_DIV:   if (r_cnt == CNT_W'(1)) n_state = cfa_pkg::MS_ROOT;
            cfa_pkg::MS_ROOT:  if (r_bit == '0) n_state = cfa_pkg::MS_HMUL;
            cfa_pkg::MS_HMUL:  n_state = cfa_pkg::MS_READY;
            cfa_pkg::MS_READY: n_state = cfa_pkg::MS_READY;
            default:           n_state = cfa_pkg::MS_PROD;
        endcase
        if (i_start) begin
            n_state = cfa_pkg::MS_PROD;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cfa_pkg::MS_PROD: begin
                r_tr    <= w_tr;
                r_tf    <= w_tf;
                r_v     <= w_v;
                r_tsum  <= w_tsum;
                r_ramps <= w_v * w_tsum;
                r_vtf   <= w_v * w_tf;
                r_cv    <= i_carb * w_v;
            end
            cfa_pkg::MS_SHAPE: begin
                r_tri <= w_p < w_ramps;
                r_n   <= w_p - w_ramps;
                r_top <= w_p - w_ramps + cfa_pkg::WIDE_W'({r_vtf, 1'b0});
                r_rem <= '0;
                r_dq  <= {r_cv, {(FRAC_BITS + 1){1'b0}}};
                r_cnt <= CNT_W'(DW);
            end
            cfa_pkg::MS_DIV: begin
                r_rem <= w_take ? (w_shift - {1'b0, r_tsum}) : w_shift;
                r_dq  <= {r_dq[DW-2:0], w_take};
                r_cnt <= r_cnt - CNT_W'(1);
                r_h   <= '0;
                r_bit <= BIT_W'(HW - 1);
            end
            cfa_pkg::MS_ROOT: begin
                if ({{(DW-SQ_W){1'b0}}, w_sq} <= r_dq) begin
                    r_h <= w_cand;
                end
                r_bit <= r_bit - BIT_W'(1);
            end
            cfa_pkg::MS_HMUL: begin
                r_htr  <= r_h * r_tr;
                r_hsum <= r_h * r_tsum;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != cfa_pkg::MS_READY) || i_start;

    always_comb begin
        o_meal.tr       = r_tr;
        o_meal.tf       = r_tf;
        o_meal.v        = r_v;
        o_meal.tsum     = r_tsum;
        o_meal.tri_mode = r_tri;
        o_meal.n        = r_n;
        o_meal.top      = r_top;
        o_meal.htr      = r_htr;
        o_meal.hsum     = r_hsum;
    end

endmodule

FILE: hw/rtl/cfa_front.sv
// two front stages: products of the sample time, then segment select
module cfa_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [cfa_pkg::TIME_W-1:0] i_time,
    input  cfa_pkg::t_meal             i_meal,
    output logic                       o_valid,
    input  logic                       i_ready,
    output cfa_pkg::t_cell             o_data
);

    localparam int PROD_W = 2 * cfa_pkg::TIME_W;

    logic                r_a_v, r_b_v;
    logic [PROD_W-1:0]   r_tv, r_vd;
    logic                r_zero, r_lt;
    cfa_pkg::t_cell      r_b, n_b;
    logic                w_ready_a, w_ready_b;
    logic [cfa_pkg::TIME_W-1:0] w_d;
    logic [cfa_pkg::WIDE_W-1:0] w_d2, w_tvw;

    assign w_ready_b = !r_b_v || i_ready;
    assign w_ready_a = !r_a_v || w_ready_b;
    assign o_ready   = w_ready_a;
    assign w_d       = i_time - cfa_pkg::TIME_W'(i_meal.tr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (w_ready_a) r_a_v <= i_valid;
            if (w_ready_b) r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_ready_a) begin
            r_tv   <= i_time * i_meal.v;
            r_vd   <= w_d * i_meal.v;
            r_zero <= i_time == '0;
            r_lt   <= i_time < cfa_pkg::TIME_W'(i_meal.tr);
        end
        if (r_a_v && w_ready_b) begin
            r_b <= n_b;
        end
    end

    assign w_d2  = cfa_pkg::WIDE_W'({r_vd, 1'b0});
    assign w_tvw = cfa_pkg::WIDE_W'(r_tv);

    // forced values go through the divider as value / 1
    always_comb begin
        n_b.tri_mode = i_meal.tri_mode;
        n_b.quo = '0;
        n_b.num = '0;
        n_b.div = cfa_pkg::TSUM_W'(1);
        if (r_zero) begin
            n_b.num = '0;
        end else if (!i_meal.tri_mode) begin
            if (r_lt) begin
                n_b.num = r_tv;
                n_b.div = cfa_pkg::TSUM_W'(i_meal.tr);
            end else if (w_d2 < i_meal.n) begin
                n_b.num = cfa_pkg::NUM_W'(i_meal.v);
            end else if (w_d2 < i_meal.top) begin
                n_b.num = cfa_pkg::NUM_W'(i_meal.top - w_d2);
                n_b.div = {i_meal.tf, 1'b0};
            end
        end else begin
            if (w_tvw < cfa_pkg::WIDE_W'(i_meal.htr)) begin
                n_b.num = r_tv;
                n_b.div = cfa_pkg::TSUM_W'(i_meal.tr);
            end else if (w_tvw < cfa_pkg::WIDE_W'(i_meal.hsum)) begin
                n_b.num = cfa_pkg::NUM_W'(cfa_pkg::WIDE_W'(i_meal.hsum) - w_tvw);
                n_b.div = cfa_pkg::TSUM_W'(i_meal.tf);
            end
        end
    end

    assign o_valid = r_b_v;
    assign o_data  = r_b;

endmodule

FILE: hw/rtl/cfa_div_cell.sv
// one divider cell: settles one quotient bit and passes the remainder on
module cfa_div_cell #(
    parameter int BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cfa_pkg::t_cell i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output cfa_pkg::t_cell o_data
);

    logic                      r_v;
    cfa_pkg::t_cell            r_d, n_d;
    logic [cfa_pkg::NUM_W-1:0] w_sd;
    logic                      w_take;

    assign o_ready = !r_v || i_ready;
    assign w_sd    = {{(cfa_pkg::NUM_W-cfa_pkg::TSUM_W){1'b0}}, i_data.div} << BIT;
    assign w_take  = i_data.num >= w_sd;

    always_comb begin
        n_d     = i_data;
        n_d.num = w_take ? (i_data.num - w_sd) : i_data.num;
        n_d.quo = {i_data.quo[cfa_pkg::QUO_W-2:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_d <= n_d;
    end

    assign o_valid = r_v;
    assign o_data  = r_d;

endmodule

FILE: hw/rtl/carb_absorption_trapezoid_rate.sv
// top level: carbohydrate flow rate at a sample time for a configured meal
//
//  channel  | direction | payload
//  s_axis   | in        | tdata[23:0] sample_time
//  m_axis   | out       | tdata[23:0] flow_rate, tuser[0] triangle_mode
//  i_cfg_*  | in        | register writes, index 0..3
//
// one request per cycle while s_axis_tready is high; a result passes through two
// front stages and a row of 24 divider cells, one quotient bit each.
// after reset and after every register write the set-up sequencer runs with
// s_axis_tready low (products, shape, divide, apex square root, apex products).
// each stage moves when the next is empty or moving, so bubbles close up
// under a stalled output while new requests are still taken.
module carb_absorption_trapezoid_rate #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] sample_time
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [23:0] flow_rate
    output logic        m_axis_tuser,   // [0] triangle_mode
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    localparam int NC = cfa_pkg::QUO_W;

    logic [cfa_pkg::AMT_W-1:0]  r_carb, r_rise, r_fall;
    logic [cfa_pkg::RATE_W-1:0] r_peak;
    logic                       w_busy, w_front_ready;
    cfa_pkg::t_meal             w_meal;

    logic           w_v   [NC+1];
    logic           w_rdy [NC+1];
    cfa_pkg::t_cell w_d   [NC+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carb <= '0;
            r_rise <= cfa_pkg::AMT_W'(256);
            r_fall <= cfa_pkg::AMT_W'(256);
            r_peak <= cfa_pkg::RATE_W'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfa_pkg::REG_CARB: r_carb <= i_cfg_data[cfa_pkg::AMT_W-1:0];
                cfa_pkg::REG_RISE: r_rise <= i_cfg_data[cfa_pkg::AMT_W-1:0];
                cfa_pkg::REG_FALL: r_fall <= i_cfg_data[cfa_pkg::AMT_W-1:0];
                cfa_pkg::REG_PEAK: r_peak <= i_cfg_data[cfa_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    cfa_meal #(.FRAC_BITS(FRAC_BITS)) u_meal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_carb  (r_carb),
        .i_rise  (r_rise),
        .i_fall  (r_fall),
        .i_peak  (r_peak),
        .o_busy  (w_busy),
        .o_meal  (w_meal)
    );

    assign s_axis_tready = w_front_ready && !w_busy;

    cfa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid && !w_busy),
        .o_ready (w_front_ready),
        .i_time  (s_axis_tdata),
        .i_meal  (w_meal),
        .o_valid (w_v[0]),
        .i_ready (w_rdy[0]),
        .o_data  (w_d[0])
    );

    for (genvar k = 0; k < NC; k++) begin : g_cell
        cfa_div_cell #(.BIT(NC - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_data  (w_d[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_data  (w_d[k+1])
        );
    end

    assign w_rdy[NC]     = m_axis_tready;
    assign m_axis_tvalid = w_v[NC];
    assign m_axis_tdata  = w_d[NC].quo;
    assign m_axis_tuser  = w_d[NC].tri_mode;

    // a trapezoid-mode result never exceeds the clamped peak rate
    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser && !w_busy) |-> (m_axis_tdata <= w_meal.v))
        else $error("flow rate above peak rate");

    // the shape flag of a result matches the set-up meal
    a_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !w_busy) |-> (m_axis_tuser == w_meal.tri_mode))
        else $error("triangle flag disagrees with meal shape");

    // a register write always reruns the set-up
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (w_busy && !s_axis_tready))
        else $error("set-up not restarted after write");

endmodule

FILE: tb/flow_rate_checker.sv
// checker: predicts flow rate and curve shape for each sample time and compares
`timescale 1ns / 1ps

module flow_rate_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [cfa_pkg::RATE_W-1:0] rate;
        logic                       tri_mode;
    } t_flow;

    logic [cfa_pkg::AMT_W-1:0]  carb_amount;
    logic [cfa_pkg::AMT_W-1:0]  rise_time;
    logic [cfa_pkg::AMT_W-1:0]  fall_time;
    logic [cfa_pkg::RATE_W-1:0] peak_rate;
    t_flow                      expected_flows[$];

    function automatic t_flow gut_flow(input logic [cfa_pkg::TIME_W-1:0] t);
        logic [127:0] tr, tf, v, p, ramps, n, d2, top, h, c, tv;
        t_flow        f;
        tr = (rise_time == 0) ? 1 : rise_time;
        tf = (fall_time == 0) ? 1 : fall_time;
        v  = (peak_rate == 0) ? 1 : peak_rate;
        p  = 128'(carb_amount) << 17;
        ramps = v * (tr + tf);
        f.tri_mode = (p < ramps);
        f.rate = '0;
        if (!f.tri_mode) begin
            n = p - ramps;
            if (t == 0)
                f.rate = '0;
            else if (t < tr)
                f.rate = cfa_pkg::RATE_W'(t * v / tr);
            else begin
                d2  = 2 * v * (t - tr);
                top = n + 2 * v * tf;
                if (d2 < n)
                    f.rate = cfa_pkg::RATE_W'(v);
                else if (d2 < top)
                    f.rate = cfa_pkg::RATE_W'((top - d2) / (2 * tf));
            end
        end else begin
            // apex height by bitwise square root
            h = 0;
            for (int b = 23; b >= 0; b--) begin
                c = h | (128'd1 << b);
                if (c * c * (tr + tf) <= p * v)
                    h = c;
            end
            tv = t * v;
            if (t == 0)
                f.rate = '0;
            else if (tv < h * tr)
                f.rate = cfa_pkg::RATE_W'(tv / tr);
            else if (tv < h * (tr + tf))
                f.rate = cfa_pkg::RATE_W'((h * (tr + tf) - tv) / tf);
        end
        return f;
    endfunction

    assign o_pending = expected_flows.size();

    always @(posedge i_clk) begin
        t_flow exp_f;
        int    errs;
        errs = 0;
        if (!i_rst_n) begin
            carb_amount <= '0;
            rise_time   <= 20'd256;
            fall_time   <= 20'd256;
            peak_rate   <= 24'd65536;
            expected_flows.delete();
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_flows.push_back(gut_flow(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (expected_flows.size() == 0) begin
                    $error("flow_rate: result with no request waiting, got %0d", i_m_tdata);
                    errs = errs + 1;
                end else begin
                    exp_f = expected_flows.pop_front();
                    if (exp_f.rate !== i_m_tdata) begin
                        $error("flow_rate: expected %0d, got %0d", exp_f.rate, i_m_tdata);
                        errs = errs + 1;
                    end
                    if (exp_f.tri_mode !== i_m_tuser) begin
                        $error("triangle_mode: expected %0d, got %0d",
                               exp_f.tri_mode, i_m_tuser);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cfa_pkg::REG_CARB: carb_amount <= i_cfg_data[cfa_pkg::AMT_W-1:0];
                    cfa_pkg::REG_RISE: rise_time   <= i_cfg_data[cfa_pkg::AMT_W-1:0];
                    cfa_pkg::REG_FALL: fall_time   <= i_cfg_data[cfa_pkg::AMT_W-1:0];
                    cfa_pkg::REG_PEAK: peak_rate   <= i_cfg_data[cfa_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: tb/testbench.sv
// testbench top: meal set-ups, sample-time stimulus, stalls and verdict
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_MEALS  = 13;
    localparam int RAND_ITEMS = 96;
    localparam int DOG_LIMIT  = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = cfa_pkg::REG_CARB;
    logic [23:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    int          idle_cycles = 0;

    logic [19:0] meal_carb, meal_rise, meal_fall;
    logic [23:0] meal_peak;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    carb_absorption_trapezoid_rate u_dut (.*);

    flow_rate_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= DOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_sample(input logic [23:0] t);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_meal(input logic [19:0] carb, input logic [19:0] rise,
                            input logic [19:0] fall, input logic [23:0] peak);
        drain_results();
        meal_carb = carb;
        meal_rise = rise;
        meal_fall = fall;
        meal_peak = peak;
        i_cfg_we <= 1'b1; i_cfg_idx <= cfa_pkg::REG_CARB; i_cfg_data <= 24'(carb);
        @(negedge i_clk);
        i_cfg_idx <= cfa_pkg::REG_RISE; i_cfg_data <= 24'(rise);
        @(negedge i_clk);
        i_cfg_idx <= cfa_pkg::REG_FALL; i_cfg_data <= 24'(fall);
        @(negedge i_clk);
        i_cfg_idx <= cfa_pkg::REG_PEAK; i_cfg_data <= peak;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] rand_width(input int maxw);
        return 24'($urandom() & ((64'd1 << $urandom_range(0, maxw)) - 1));
    endfunction

    task automatic run_samples;
        logic [63:0] tr, tf, v, span, t;
        logic [23:0] pick;
        tr = (meal_rise == 0) ? 1 : meal_rise;
        tf = (meal_fall == 0) ? 1 : meal_fall;
        v  = (meal_peak == 0) ? 1 : meal_peak;
        // rough end of the curve: ramps plus plateau
        span = tr + tf + ((64'(meal_carb) << 17) / (2 * v)) + 4;
        if (span > 64'hFFFFFF) span = 64'hFFFFFF;
        send_sample(24'd0);
        send_sample(24'd1);
        send_sample(24'hFFFFFF);
        send_sample(24'(tr - 1));
        send_sample(24'(tr));
        send_sample(24'(tr + 1));
        send_sample(24'(span));
        send_sample(24'(tr + tf));
        repeat (RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1:    t = $urandom_range(0, 32'(tr));
                2:       t = tr + $urandom_range(0, 6) - 3;
                3:       t = span - $urandom_range(0, 8);
                4, 5:    t = $urandom() & 32'hFFFFFF;
                default: t = $urandom_range(0, 32'(span));
            endcase
            pick = 24'(t);
            send_sample(pick);
        end
    endtask

    initial begin
        meal_carb = 20'd0; meal_rise = 20'd256; meal_fall = 20'd256; meal_peak = 24'd65536;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_samples();
        for (int m = 0; m < NUM_MEALS; m++) begin
            case (m)
                0: set_meal(20'hFFFFF, 20'd1, 20'd1, 24'hFFFFFF);
                1: set_meal(20'd0, 20'hFFFFF, 20'hFFFFF, 24'd1);
                2: set_meal(20'd1000, 20'd0, 20'd0, 24'd0);
                3: set_meal(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF);
                4: set_meal(20'd15360, 20'd3840, 20'd15360, 24'd32768);
                5: set_meal(20'd2560, 20'd7680, 20'd15360, 24'd131072);
                default: set_meal(20'(rand_width(20)), 20'(rand_width(20)),
                                  20'(rand_width(20)), rand_width(24));
            endcase
            if (m == 2) hold_req = 1'b1;
            if (m == NUM_MEALS - 1) calm = 1'b1;
            run_samples();
        end
        drain_results();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/cfa_pkg.sv
hw/rtl/cfa_meal.sv
hw/rtl/cfa_front.sv
hw/rtl/cfa_div_cell.sv
hw/rtl/carb_absorption_trapezoid_rate.sv
tb/flow_rate_checker.sv
tb/testbench.sv
